// File: design/assert_macros.svh
// Assertion macros shared by the box filter RTL.
// Each macro expects signals clk and arst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising clock edge outside reset.
`define RBF_ASSERT_IMPLY(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("box filter implication check failed");

// Condition that must never hold at a rising clock edge outside reset.
`define RBF_ASSERT_NEVER(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("box filter forbidden condition seen");

`endif

// File: design/rbf_pkg.sv
// Package for the RGB box filter: result word type, register indexes, FIFO size.
// Used by rbf_fifo, rgb_box_filter_valid and the testbench; depends on nothing.
package rbf_pkg;

	localparam int unsigned PIX_W = 8;
	localparam int unsigned NUM_CH = 3;
	localparam int unsigned CFG_W = 11;
	localparam int unsigned FIFO_DEPTH = 8;
	localparam int unsigned FIFO_AW = $clog2(FIFO_DEPTH);
	localparam int unsigned CREDIT_W = $clog2(FIFO_DEPTH + 1);

	// Configuration register indexes.
	localparam logic CFG_FRAME_WIDTH = 1'b0;
	localparam logic CFG_FRAME_HEIGHT = 1'b1;

	typedef struct packed {
		logic frame_end;
		logic [PIX_W-1:0] blue;
		logic [PIX_W-1:0] green;
		logic [PIX_W-1:0] red;
	} result_t;

endpackage

// File: design/rbf_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
// Stand-alone; used for the line store and the column sum store.
module rbf_ram #(
	parameter int unsigned WIDTH = 24,
	parameter int unsigned DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: design/rbf_cell.sv
// One cell of the column sum delay chain: holds one column's three sums and
// passes them to its neighbor each time a pixel moves through. No dependencies.
module rbf_cell #(
	parameter int unsigned WIDTH = 36
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             shift,
	input  logic [WIDTH-1:0] d,
	output logic [WIDTH-1:0] q
);

	logic [WIDTH-1:0] sums_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sums_q <= '0;
		end else if (shift) begin
			sums_q <= d;
		end
	end

	assign q = sums_q;

endmodule

// File: design/rbf_fifo.sv
// Small output FIFO for result words of the box filter.
// Depends on rbf_pkg for the word type and the depth.
module rbf_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  rbf_pkg::result_t wdata,
	input  logic             pop,
	output rbf_pkg::result_t rdata,
	output logic             not_empty,
	output logic             full
);
	import rbf_pkg::*;

	result_t mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q;
	logic [FIFO_AW-1:0] rd_ptr_q;
	logic [FIFO_AW:0]   count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign rdata = mem_q[rd_ptr_q];
	assign not_empty = (count_q != '0);
	assign full = (count_q == (FIFO_AW + 1)'(FIFO_DEPTH));

endmodule

// File: design/rgb_box_filter_valid.sv
// RGB box filter, 'valid' output. While it holds output credits, the block takes
// one RGB pixel word per clock in raster order and returns, for each position whose
// whole KERNEL_SIZE-square window lies inside the frame, the truncated per-channel
// mean of that window; the output frame is (height-K+1) by (width-K+1) and its
// bottom-right word carries frame_end. frame_width and frame_height are clamped to
// [K, MAX_WIDTH] and [K, MAX_HEIGHT]. Throughput is one pixel per clock while
// credits remain: the line store and the column sum store each see one read and one
// write per pixel, and the window sum is a running sum whose oldest column comes out
// of a chain of K cells. An eight-word output FIFO with credit counting lets the
// input keep flowing while results wait downstream. No clearing pass is needed after
// reset.
`include "assert_macros.svh"

module rgb_box_filter_valid #(
	parameter int unsigned KERNEL_SIZE = 11,
	parameter int unsigned MAX_WIDTH = 1024,
	parameter int unsigned MAX_HEIGHT = 1024
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic                       cfg_index,
	input  logic [rbf_pkg::CFG_W-1:0]  cfg_data,
	input  logic                       pix_valid,
	output logic                       pix_ready,
	input  logic                       frame_start,
	input  logic [rbf_pkg::PIX_W-1:0]  red_in,
	input  logic [rbf_pkg::PIX_W-1:0]  green_in,
	input  logic [rbf_pkg::PIX_W-1:0]  blue_in,
	output logic                       mean_valid,
	input  logic                       mean_ready,
	output logic [rbf_pkg::PIX_W-1:0]  red_out,
	output logic [rbf_pkg::PIX_W-1:0]  green_out,
	output logic [rbf_pkg::PIX_W-1:0]  blue_out,
	output logic                       frame_end
);
	import rbf_pkg::*;

	// Widths that follow from the parameters.
	localparam int unsigned CW = $clog2(MAX_WIDTH);
	localparam int unsigned RW = $clog2(MAX_HEIGHT);
	localparam int unsigned KW = $clog2(KERNEL_SIZE);
	localparam int unsigned WDW = $clog2(MAX_WIDTH + 1);
	localparam int unsigned HDW = $clog2(MAX_HEIGHT + 1);
	localparam int unsigned AREA = KERNEL_SIZE * KERNEL_SIZE;
	localparam int unsigned COL_W = $clog2(KERNEL_SIZE * 255 + 1);
	localparam int unsigned SUM_W = $clog2(AREA * 255 + 1);
	localparam int unsigned PIXW3 = NUM_CH * PIX_W;
	localparam int unsigned COLW3 = NUM_CH * COL_W;
	localparam int unsigned LS_DEPTH = KERNEL_SIZE << CW;
	localparam int unsigned LS_AW = $clog2(LS_DEPTH);
	// Division by AREA as a multiply by a rounded-up reciprocal; exact for SUM_W bits.
	localparam int unsigned SHIFT = SUM_W + $clog2(AREA);
	localparam longint unsigned RECIP_L = ((64'd1 << SHIFT) + AREA - 1) / AREA;
	localparam int unsigned RCP_W = SUM_W + 1;
	localparam logic [RCP_W-1:0] RECIP = RCP_W'(RECIP_L);
	localparam int unsigned PROD_W = SUM_W + RCP_W;

	// Configuration registers.
	logic [CFG_W-1:0] frame_width_q;
	logic [CFG_W-1:0] frame_height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q <= CFG_W'(1024);
			frame_height_q <= CFG_W'(1024);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_FRAME_WIDTH:  frame_width_q <= cfg_data;
				CFG_FRAME_HEIGHT: frame_height_q <= cfg_data;
				default:          frame_width_q <= frame_width_q;
			endcase
		end
	end

	logic [WDW-1:0] width_use;
	logic [HDW-1:0] height_use;

	always_comb begin
		if (32'(frame_width_q) < KERNEL_SIZE) begin
			width_use = WDW'(KERNEL_SIZE);
		end else if (32'(frame_width_q) > MAX_WIDTH) begin
			width_use = WDW'(MAX_WIDTH);
		end else begin
			width_use = WDW'(frame_width_q);
		end
		if (32'(frame_height_q) < KERNEL_SIZE) begin
			height_use = HDW'(KERNEL_SIZE);
		end else if (32'(frame_height_q) > MAX_HEIGHT) begin
			height_use = HDW'(MAX_HEIGHT);
		end else begin
			height_use = HDW'(frame_height_q);
		end
	end

	// Handshake and credits. A credit is one FIFO slot reserved for an accepted word.
	logic                accept;
	logic [CREDIT_W-1:0] credit_q;
	logic                fifo_pop;
	logic                fifo_full;
	logic                fifo_not_empty;

	assign pix_ready = (credit_q != '0);
	assign accept = pix_valid && pix_ready;

	// Position counters and the row index modulo K.
	logic [CW-1:0]  column_count_q;
	logic [RW-1:0]  row_count_q;
	logic [KW-1:0]  row_mod_q;
	logic [CW:0]    fill_mark_q;
	logic [CW-1:0]  col_s0;
	logic [RW-1:0]  row_s0;
	logic [KW-1:0]  rmod_s0;
	logic           last_col_s0;
	logic           last_row_s0;
	logic           has_result_s0;
	logic           is_end_s0;
	logic           col_written_s0;

	always_comb begin
		logic [RW:0] row_t;
		col_s0 = column_count_q;
		row_t = {1'b0, row_count_q};
		rmod_s0 = row_mod_q;
		if (frame_start) begin
			col_s0 = '0;
			row_t = '0;
			rmod_s0 = '0;
		end else begin
			if (32'(column_count_q) >= 32'(width_use)) begin
				col_s0 = '0;
				row_t = row_t + 1'b1;
				rmod_s0 = (row_mod_q == KW'(KERNEL_SIZE - 1)) ? '0 : row_mod_q + 1'b1;
			end
			if (32'(row_t) >= 32'(height_use)) begin
				row_t = '0;
				rmod_s0 = '0;
			end
		end
		row_s0 = row_t[RW-1:0];
		last_col_s0 = (32'(col_s0) + 1 >= 32'(width_use));
		last_row_s0 = (32'(row_s0) + 1 >= 32'(height_use));
		has_result_s0 = (32'(row_s0) + 1 >= KERNEL_SIZE) && (32'(col_s0) + 1 >= KERNEL_SIZE);
		is_end_s0 = (32'(row_s0) + 1 == 32'(height_use)) && (32'(col_s0) + 1 == 32'(width_use));
		// Column sums are written left to right from column zero, so every
		// column below the fill mark has been written since reset.
		col_written_s0 = (32'(col_s0) < 32'(fill_mark_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_count_q <= '0;
			row_count_q <= '0;
			row_mod_q <= '0;
			fill_mark_q <= '0;
		end else if (accept) begin
			if (last_col_s0) begin
				column_count_q <= '0;
				if (last_row_s0) begin
					row_count_q <= '0;
					row_mod_q <= '0;
				end else begin
					row_count_q <= row_s0 + 1'b1;
					row_mod_q <= (rmod_s0 == KW'(KERNEL_SIZE - 1)) ? '0 : rmod_s0 + 1'b1;
				end
			end else begin
				column_count_q <= col_s0 + 1'b1;
				row_count_q <= row_s0;
				row_mod_q <= rmod_s0;
			end
			if (!col_written_s0) begin
				fill_mark_q <= (CW + 1)'(col_s0) + 1'b1;
			end
		end
	end

	// Stage 1: store reads come back; pixel and position flags follow.
	logic             v_s1;
	logic             res_s1;
	logic             end_s1;
	logic             row_zero_s1;
	logic             row_full_s1;
	logic             col_zero_s1;
	logic             col_sub_s1;
	logic             col_written_s1;
	logic [PIXW3-1:0] pix_s1;
	logic [LS_AW-1:0] ls_addr_s1;
	logic [CW-1:0]    col_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_s1 <= has_result_s0;
			end_s1 <= is_end_s0;
			row_zero_s1 <= (row_s0 == '0);
			row_full_s1 <= (32'(row_s0) >= KERNEL_SIZE);
			col_zero_s1 <= (col_s0 == '0);
			col_sub_s1 <= (32'(col_s0) >= KERNEL_SIZE);
			col_written_s1 <= col_written_s0;
			pix_s1 <= {blue_in, green_in, red_in};
			ls_addr_s1 <= {rmod_s0, col_s0};
			col_s1 <= col_s0;
		end
	end

	logic [PIXW3-1:0] ls_rdata;
	logic [COLW3-1:0] cs_rdata;
	logic [COLW3-1:0] new_col_s1;
	logic [COLW3-1:0] chain_out;
	logic [SUM_W-1:0] win_q [NUM_CH];
	logic [SUM_W-1:0] win_n [NUM_CH];

	rbf_ram #(
		.WIDTH(PIXW3),
		.DEPTH(LS_DEPTH)
	) u_line_store (
		.clk  (clk),
		.we   (v_s1),
		.waddr(ls_addr_s1),
		.wdata(pix_s1),
		.re   (accept),
		.raddr({rmod_s0, col_s0}),
		.rdata(ls_rdata)
	);

	rbf_ram #(
		.WIDTH(COLW3),
		.DEPTH(1 << CW)
	) u_col_store (
		.clk  (clk),
		.we   (v_s1),
		.waddr(col_s1),
		.wdata(new_col_s1),
		.re   (accept),
		.raddr(col_s0),
		.rdata(cs_rdata)
	);

	// New column sum: restart on row zero, accumulate while the column is
	// filling, then add the new pixel and drop the one from K rows above.
	always_comb begin
		logic [COL_W-1:0] old_col;
		logic [COL_W-1:0] px;
		logic [COL_W-1:0] od;
		logic [COL_W-1:0] nc;
		logic [COL_W-1:0] sub;
		for (int ch = 0; ch < NUM_CH; ch++) begin
			px = COL_W'(pix_s1[ch*PIX_W +: PIX_W]);
			od = COL_W'(ls_rdata[ch*PIX_W +: PIX_W]);
			old_col = col_written_s1 ? cs_rdata[ch*COL_W +: COL_W] : '0;
			if (row_zero_s1) begin
				nc = px;
			end else if (row_full_s1) begin
				nc = old_col + px - od;
			end else begin
				nc = old_col + px;
			end
			new_col_s1[ch*COL_W +: COL_W] = nc;
			sub = col_sub_s1 ? chain_out[ch*COL_W +: COL_W] : '0;
			if (col_zero_s1) begin
				win_n[ch] = SUM_W'(nc);
			end else begin
				win_n[ch] = win_q[ch] + SUM_W'(nc) - SUM_W'(sub);
			end
		end
	end

	// Chain of K cells: the last cell holds the column sum from K columns back.
	logic [COLW3-1:0] chain_q [KERNEL_SIZE];

	for (genvar i = 0; i < KERNEL_SIZE; i++) begin : g_chain
		rbf_cell #(
			.WIDTH(COLW3)
		) u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.shift (v_s1),
			.d     ((i == 0) ? new_col_s1 : chain_q[(i == 0) ? 0 : i - 1]),
			.q     (chain_q[i])
		);
	end

	assign chain_out = chain_q[KERNEL_SIZE - 1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int ch = 0; ch < NUM_CH; ch++) begin
				win_q[ch] <= '0;
			end
		end else if (v_s1) begin
			for (int ch = 0; ch < NUM_CH; ch++) begin
				win_q[ch] <= win_n[ch];
			end
		end
	end

	// Stage 2: window sums of words that give a result.
	logic             v_s2;
	logic             end_s2;
	logic [SUM_W-1:0] win_s2 [NUM_CH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1 && res_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			end_s2 <= end_s1;
			for (int ch = 0; ch < NUM_CH; ch++) begin
				win_s2[ch] <= win_n[ch];
			end
		end
	end

	// Stage 3: mean = (sum * RECIP) >> SHIFT, registered straight from the product.
	logic             v_s3;
	result_t          res_s3;
	logic [PROD_W-1:0] prod [NUM_CH];

	always_comb begin
		for (int ch = 0; ch < NUM_CH; ch++) begin
			prod[ch] = PROD_W'(win_s2[ch]) * PROD_W'(RECIP);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s2) begin
			res_s3.frame_end <= end_s2;
			res_s3.red <= prod[0][SHIFT +: PIX_W];
			res_s3.green <= prod[1][SHIFT +: PIX_W];
			res_s3.blue <= prod[2][SHIFT +: PIX_W];
		end
	end

	result_t fifo_rdata;

	rbf_fifo u_out_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (v_s3),
		.wdata    (res_s3),
		.pop      (fifo_pop),
		.rdata    (fifo_rdata),
		.not_empty(fifo_not_empty),
		.full     (fifo_full)
	);

	assign fifo_pop = fifo_not_empty && mean_ready;
	assign mean_valid = fifo_not_empty;
	assign red_out = fifo_rdata.red;
	assign green_out = fifo_rdata.green;
	assign blue_out = fifo_rdata.blue;
	assign frame_end = fifo_rdata.frame_end;

	// A credit returns when a pixel turns out to give no result, or when a word leaves.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			credit_q <= CREDIT_W'(FIFO_DEPTH);
		end else begin
			credit_q <= CREDIT_W'(32'(credit_q) + 32'(v_s1 && !res_s1) + 32'(fifo_pop)
				- 32'(accept));
		end
	end

	// Checks.
	`RBF_ASSERT_NEVER(a_credit_bound, 32'(credit_q) > FIFO_DEPTH)
	`RBF_ASSERT_NEVER(a_no_overflow, v_s3 && fifo_full && !fifo_pop)
	`RBF_ASSERT_IMPLY(a_start_restarts, accept && frame_start, ##1 (row_zero_s1 && col_zero_s1))
	`RBF_ASSERT_IMPLY(a_result_follows, v_s1 && res_s1, ##2 v_s3)

endmodule

// File: tb/rbf_checker.sv
// Checker for the RGB box filter: watches the register port and both word channels,
// predicts the mean words and compares them. Depends on rbf_pkg.
`timescale 1ns / 100ps

module rbf_checker #(
	parameter int unsigned KERNEL_SIZE = 11,
	parameter int unsigned MAX_WIDTH = 1024,
	parameter int unsigned MAX_HEIGHT = 1024
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic                      cfg_index,
	input  logic [rbf_pkg::CFG_W-1:0] cfg_data,
	input  logic                      pix_valid,
	input  logic                      pix_ready,
	input  logic                      frame_start,
	input  logic [rbf_pkg::PIX_W-1:0] red_in,
	input  logic [rbf_pkg::PIX_W-1:0] green_in,
	input  logic [rbf_pkg::PIX_W-1:0] blue_in,
	input  logic                      mean_valid,
	input  logic                      mean_ready,
	input  logic [rbf_pkg::PIX_W-1:0] red_out,
	input  logic [rbf_pkg::PIX_W-1:0] green_out,
	input  logic [rbf_pkg::PIX_W-1:0] blue_out,
	input  logic                      frame_end,
	output int                        fail_count,
	output int                        means_pending
);
	import rbf_pkg::*;

	logic [23:0] line_store [KERNEL_SIZE*MAX_WIDTH];
	logic [31:0] col_sum [NUM_CH][MAX_WIDTH];
	logic [31:0] win_sum [NUM_CH];
	int unsigned next_col, next_row;
	int unsigned width_reg, height_reg;
	result_t expected_means [$];

	initial begin
		foreach (line_store[i]) line_store[i] = '0;
		foreach (col_sum[ch, i]) col_sum[ch][i] = '0;
		fail_count = 0;
		means_pending = 0;
	end

	function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
		if (v < KERNEL_SIZE) return KERNEL_SIZE;
		if (v > hi) return hi;
		return v;
	endfunction

	task automatic filter_pixel(logic fs, logic [7:0] rv, logic [7:0] gv, logic [7:0] bv);
		int unsigned w, h, c, r, slot;
		logic [7:0] px [NUM_CH];
		logic [7:0] od [NUM_CH];
		logic [23:0] old_word;
		result_t res;
		w = clamp_dim(width_reg, MAX_WIDTH);
		h = clamp_dim(height_reg, MAX_HEIGHT);
		if (fs) begin
			c = 0;
			r = 0;
		end else begin
			c = next_col;
			r = next_row;
			if (c >= w) begin
				c = 0;
				r++;
			end
			if (r >= h) r = 0;
		end
		px[0] = rv;
		px[1] = gv;
		px[2] = bv;
		slot = (r % KERNEL_SIZE) * MAX_WIDTH + c;
		old_word = line_store[slot];
		od[0] = old_word[7:0];
		od[1] = old_word[15:8];
		od[2] = old_word[23:16];
		line_store[slot] = {bv, gv, rv};
		for (int ch = 0; ch < NUM_CH; ch++) begin
			if (r == 0) col_sum[ch][c] = 32'(px[ch]);
			else if (r < KERNEL_SIZE) col_sum[ch][c] += 32'(px[ch]);
			else col_sum[ch][c] = col_sum[ch][c] + 32'(px[ch]) - 32'(od[ch]);
			if (c == 0) begin
				win_sum[ch] = col_sum[ch][0];
			end else begin
				win_sum[ch] += col_sum[ch][c];
				if (c >= KERNEL_SIZE) win_sum[ch] -= col_sum[ch][c-KERNEL_SIZE];
			end
		end
		if (c + 1 >= w) begin
			next_col = 0;
			next_row = (r + 1 >= h) ? 0 : r + 1;
		end else begin
			next_col = c + 1;
			next_row = r;
		end
		if (r + 1 >= KERNEL_SIZE && c + 1 >= KERNEL_SIZE) begin
			res.red = 8'(win_sum[0] / (KERNEL_SIZE*KERNEL_SIZE));
			res.green = 8'(win_sum[1] / (KERNEL_SIZE*KERNEL_SIZE));
			res.blue = 8'(win_sum[2] / (KERNEL_SIZE*KERNEL_SIZE));
			res.frame_end = (r + 1 == h && c + 1 == w);
			expected_means.push_back(res);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			next_col = 0;
			next_row = 0;
			width_reg = 1024;
			height_reg = 1024;
			foreach (win_sum[ch]) win_sum[ch] = '0;
			expected_means.delete();
		end else begin
			if (mean_valid && mean_ready) begin
				if (expected_means.size() == 0) begin
					$error("unexpected mean word: red %0d green %0d blue %0d end %0b",
						red_out, green_out, blue_out, frame_end);
					fail_count++;
				end else begin
					want = expected_means.pop_front();
					if (red_out !== want.red) begin
						$error("red_out: expected %0d, got %0d", want.red, red_out);
						fail_count++;
					end
					if (green_out !== want.green) begin
						$error("green_out: expected %0d, got %0d", want.green, green_out);
						fail_count++;
					end
					if (blue_out !== want.blue) begin
						$error("blue_out: expected %0d, got %0d", want.blue, blue_out);
						fail_count++;
					end
					if (frame_end !== want.frame_end) begin
						$error("frame_end: expected %0b, got %0b", want.frame_end, frame_end);
						fail_count++;
					end
				end
			end
			if (pix_valid && pix_ready)
				filter_pixel(frame_start, red_in, green_in, blue_in);
			if (cfg_we) begin
				if (cfg_index == CFG_FRAME_WIDTH) width_reg = cfg_data;
				else if (cfg_index == CFG_FRAME_HEIGHT) height_reg = cfg_data;
			end
		end
		means_pending = expected_means.size();
	end

endmodule

// File: tb/tb_top.sv
// Top of the RGB box filter testbench: clock, reset, register writes and pixel stimulus.
// Depends on rbf_pkg, rgb_box_filter_valid and rbf_checker.
`timescale 1ns / 100ps

module tb_top;
	import rbf_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic cfg_index = CFG_FRAME_WIDTH;
	logic [CFG_W-1:0] cfg_data = '0;
	logic pix_valid = 1'b0;
	logic pix_ready;
	logic frame_start = 1'b0;
	logic [PIX_W-1:0] red_in = '0, green_in = '0, blue_in = '0;
	logic mean_valid;
	logic mean_ready = 1'b0;
	logic [PIX_W-1:0] red_out, green_out, blue_out;
	logic frame_end;
	int fail_count, means_pending;

	// Chance, in percent, that the sender holds a word back or the receiver stalls.
	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned pixels_sent = 0;

	always #5 clk = ~clk;

	rgb_box_filter_valid u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.pix_valid(pix_valid), .pix_ready(pix_ready), .frame_start(frame_start),
		.red_in(red_in), .green_in(green_in), .blue_in(blue_in),
		.mean_valid(mean_valid), .mean_ready(mean_ready),
		.red_out(red_out), .green_out(green_out), .blue_out(blue_out),
		.frame_end(frame_end)
	);

	rbf_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.pix_valid(pix_valid), .pix_ready(pix_ready), .frame_start(frame_start),
		.red_in(red_in), .green_in(green_in), .blue_in(blue_in),
		.mean_valid(mean_valid), .mean_ready(mean_ready),
		.red_out(red_out), .green_out(green_out), .blue_out(blue_out),
		.frame_end(frame_end),
		.fail_count(fail_count), .means_pending(means_pending)
	);

	// The receiver decides at every falling edge whether it takes a word in the next cycle.
	always @(negedge clk) begin
		mean_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Sends one pixel word. Idle cycles come before the word, so valid never drops
	// between back-to-back words and stays steady until the handshake completes.
	task automatic send_pixel(logic fs, logic [7:0] rv, logic [7:0] gv, logic [7:0] bv);
		while ($urandom_range(99) < send_idle_pct) begin
			pix_valid = 1'b0;
			@(negedge clk);
		end
		frame_start = fs;
		red_in = rv;
		green_in = gv;
		blue_in = bv;
		pix_valid = 1'b1;
		do @(posedge clk); while (!pix_ready);
		@(negedge clk);
		pixels_sent++;
	endtask

	// Register writes happen only when the filter is idle: every expected mean word has
	// come out, and a further wait covers pixels still inside the pipeline.
	task automatic write_reg(logic idx, logic [CFG_W-1:0] value);
		pix_valid = 1'b0;
		while (means_pending != 0) @(negedge clk);
		repeat (12) @(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = value;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// Sends one frame of w by h pixels, or only its first n_pix pixels when n_pix is
	// smaller. Pixel style: 0 random, 1 all white, 2 all black, 3 black and white
	// checkerboard, 4 dark random values.
	task automatic send_frame(int unsigned w, int unsigned h, logic fs, int unsigned style,
		int unsigned n_pix);
		logic [7:0] rv, gv, bv;
		int unsigned k;
		k = 0;
		for (int unsigned r = 0; r < h; r++) begin
			for (int unsigned c = 0; c < w; c++) begin
				if (k >= n_pix) return;
				case (style)
					1: {rv, gv, bv} = {3{8'hFF}};
					2: {rv, gv, bv} = '0;
					3: {rv, gv, bv} = ((r + c) % 2) ? {3{8'hFF}} : '0;
					4: {rv, gv, bv} = {8'($urandom_range(15)), 8'($urandom_range(15)),
						8'($urandom_range(15))};
					default: {rv, gv, bv} = {8'($urandom), 8'($urandom), 8'($urandom)};
				endcase
				send_pixel(k == 0 ? fs : 1'b0, rv, gv, bv);
				k++;
			end
		end
	endtask

	initial begin
		int unsigned w, h, goal, n_frames;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed part: the smallest frame with saturated and alternating pixels,
		// a frame start in the middle of a frame, and a frame without a frame start.
		write_reg(CFG_FRAME_WIDTH, 11'd11);
		write_reg(CFG_FRAME_HEIGHT, 11'd11);
		send_frame(11, 11, 1'b1, 1, 121);
		send_frame(11, 11, 1'b0, 3, 121);
		send_frame(11, 11, 1'b1, 0, 60);
		send_frame(11, 11, 1'b1, 2, 121);

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 65; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 65; end
				default: begin send_idle_pct = 34; recv_stall_pct = 34; end
			endcase

			// Register extremes: values below the kernel size and above the largest
			// frame are clamped. The widest and tallest frames are cut short just past
			// the point where a wrong clamp would wrap the row or the frame too early.
			case (phase)
				0: begin
					write_reg(CFG_FRAME_WIDTH, 11'h7FF);
					write_reg(CFG_FRAME_HEIGHT, 11'h000);
					send_frame(1024, 11, 1'b1, 0, 1030);
				end
				1: begin
					write_reg(CFG_FRAME_WIDTH, 11'h000);
					write_reg(CFG_FRAME_HEIGHT, 11'h7FF);
					send_frame(11, 1024, 1'b1, 0, 11*12);
				end
				2: begin
					write_reg(CFG_FRAME_WIDTH, 11'h000);
					write_reg(CFG_FRAME_HEIGHT, 11'h000);
					send_frame(11, 11, 1'b1, 4, 121);
				end
				default: ;
			endcase

			goal = pixels_sent + 100;
			while (pixels_sent < goal) begin
				w = ($urandom_range(9) == 0) ? $urandom_range(11, 64) : $urandom_range(11, 16);
				h = $urandom_range(11, 15);
				write_reg(CFG_FRAME_WIDTH, 11'(w));
				write_reg(CFG_FRAME_HEIGHT, 11'(h));
				n_frames = $urandom_range(1, 2);
				for (int f = 0; f < n_frames; f++) begin
					// The first frame after a register write always carries a frame start;
					// later ones sometimes rely on the position counters wrapping. A few
					// frames are cut short and followed by a frame start.
					if ($urandom_range(9) == 0) begin
						send_frame(w, h, 1'b1, 0, $urandom_range(1, w*h - 1));
						send_frame(w, h, 1'b1, $urandom_range(4), w*h);
					end else begin
						send_frame(w, h, (f == 0) || ($urandom_range(3) != 0),
							($urandom_range(4) == 0) ? $urandom_range(1, 4) : 0, w*h);
					end
				end
			end
		end

		pix_valid = 1'b0;
		while (means_pending != 0) @(negedge clk);
		repeat (20) @(negedge clk);
		if (fail_count == 0)
			$display("rgb_box_filter_valid regression: pass");
		else
			$display("rgb_box_filter_valid regression: fail");
		$finish;
	end

	// Watchdog: the slowest correct run needs well under a tenth of this.
	initial begin
		#20ms;
		$display("rgb_box_filter_valid regression: fail");
		$finish;
	end

endmodule

// File: files.f
+incdir+design
design/rbf_pkg.sv
design/rbf_ram.sv
design/rbf_cell.sv
design/rbf_fifo.sv
design/rgb_box_filter_valid.sv
tb/rbf_checker.sv
tb/tb_top.sv
